// ===== rtl/csr_pkg.sv =====
// Shared constants, types and helpers of the clock skew regression block.
// Used by the divider, datapath, controller and top level; depends on nothing.
`default_nettype none
package csr_pkg;

    localparam int TABLE_DEPTH = 8;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CHECK_MIN   = 3;
    localparam int TIME_W      = 32;
    localparam int SUM_W       = 64;
    localparam int SKEW_W      = 48;
    localparam int SKEW_FRAC   = 40;
    localparam int LIMIT_W     = 16;
    localparam int FLIM_W      = 4;
    localparam int OUTCNT_W    = 4;

    localparam logic [LIMIT_W-1:0] THROWOUT_RESET = 16'd30;
    localparam logic [FLIM_W-1:0]  FAULT_RESET    = 4'd3;

    localparam logic [SUM_W-1:0] SKEW_MAXNEG = 64'h0000_8000_0000_0000;
    localparam logic [SUM_W-1:0] SKEW_MAXPOS = 64'h0000_7FFF_FFFF_FFFF;

    typedef logic [1:0] op_t;
    localparam op_t OP_ADD = 2'd0;
    localparam op_t OP_L2G = 2'd1;
    localparam op_t OP_G2L = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_ADDED       = 2'd0;
    localparam status_t ST_DROPPED     = 2'd1;
    localparam status_t ST_FAULT_RESET = 2'd2;
    localparam status_t ST_CONVERTED   = 2'd3;

    localparam logic REG_THROWOUT = 1'b0;
    localparam logic REG_FAULT    = 1'b1;

    typedef enum logic [5:0] {
        C_NOP, C_LOAD, C_FIRST, C_CONV_LD, C_MUL_SLO, C_MUL_SHI, C_TERM, C_CHECK,
        C_RD_OLD, C_OLD_LATCH, C_SUB_OLD, C_CLR_SUMS, C_RD_LOOP, C_REN_XY,
        C_MUL_XX, C_MUL_YX, C_WRITE, C_ORIGIN, C_NEW_XY, C_WRITE_NEW,
        C_DIV_AX, C_SET_LA, C_DIV_AY, C_SET_OA, C_SKEW_ZERO,
        C_MUL_LA_YLO, C_MUL_LA_YHI, C_NUM, C_MUL_LA_XLO, C_MUL_LA_XHI, C_DEN,
        C_DIV_SK, C_SKEW_SET, C_OUT
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic above_min;
        logic err;
        logic renorm;
        logic ren_done;
        logic div_busy;
        logic single;
        logic den_zero;
        logic out_free;
    } dp_stat_t;

    // Ring index arithmetic that also holds for depths that are not powers of two.
    function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {{(CNT_W + 1 - IDX_W){1'b0}}, a} + {1'b0, b};
        if (s >= (CNT_W + 1)'(TABLE_DEPTH)) begin
            s = s - (CNT_W + 1)'(TABLE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/clock_skew_regression_sync.sv =====
// Top level of the clock skew regression engine: controller plus datapath.
// Depends on csr_pkg, csr_ctrl, csr_dp and csr_div.
//
// Usage:
// - Input channel s_*: one word per handshake carries an op (add sync point,
//   local to global, global to local) and a global/local stamp pair.
// - Result channel m_*: exactly one word per input word, in order, with the
//   converted time, a status code and the number of points held.
// - Config port: cfg_we writes cfg_wdata to register cfg_index at the clock
//   edge (0 throwout limit, 1 fault limit); write only while idle.
// - One word is processed at a time. In an add, two average divisions and
//   a skew division in the shared bit-serial divider dominate, and a
//   renormalization steps through the table entries one at a time via the
//   single-port point table and the shared 32x32 multiplier.
// - The result sits in an output register, so the next input word is taken
//   while a result still waits; a stalled receiver only holds the block once
//   the following result is ready to be loaded.
// - Synchronous reset clears the sums, origins, skew and counts and restores
//   the register defaults; the point table is not cleared.
`default_nettype none
module clock_skew_regression_sync (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_op,
    input  logic [csr_pkg::TIME_W-1:0]   s_stamp_global,
    input  logic [csr_pkg::TIME_W-1:0]   s_stamp_local,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [csr_pkg::TIME_W-1:0]   m_converted_time,
    output logic [1:0]                   m_status,
    output logic [csr_pkg::OUTCNT_W-1:0] m_entry_count,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [csr_pkg::LIMIT_W-1:0]  cfg_wdata
);
    import csr_pkg::*;

    cmd_t     cmd;
    dp_stat_t stat;

    csr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    csr_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_op             (s_op),
        .s_stamp_global   (s_stamp_global),
        .s_stamp_local    (s_stamp_local),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_converted_time (m_converted_time),
        .m_status         (m_status),
        .m_entry_count    (m_entry_count)
    );

    // Only one word is in flight, so the input closes right after a handshake.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a word is in flight");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_entry_count <= OUTCNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_conv_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_CONVERTED |-> m_converted_time == '0)
        else $error("nonzero time on a word that is not a conversion");

    // A result is loaded only from the output state, never while idle.
    a_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result loaded while the controller was idle");

endmodule
`default_nettype wire

// ===== rtl/csr_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, with an overflow flag.
// Depends on csr_pkg for widths and the saturation bound.
`default_nettype none
module csr_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic                      frac,
    input  logic [csr_pkg::SUM_W-1:0] dividend,
    input  logic [csr_pkg::SUM_W-1:0] divisor,
    output logic                      busy,
    output logic [csr_pkg::SUM_W-1:0] quotient,
    output logic                      ovf
);
    import csr_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + SKEW_FRAC);

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] last_reg;
    logic [SUM_W-1:0]  dvd_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  den_reg;
    logic [SUM_W-1:0]  q_reg;
    logic              ovf_reg;

    logic [SUM_W-1:0]  rem_sh;
    logic              take;
    logic [SUM_W-1:0]  rem_next;
    logic [SUM_W-1:0]  q_next;

    // The remainder carry out covers divisors at or above half the word range.
    always_comb begin
        rem_sh   = {rem_reg[SUM_W-2:0], dvd_reg[SUM_W-1]};
        take     = rem_reg[SUM_W-1] || (rem_sh >= den_reg);
        rem_next = take ? rem_sh - den_reg : rem_sh;
        q_next   = {q_reg[SUM_W-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && step_reg == last_reg) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            step_reg <= '0;
            last_reg <= frac ? STEP_W'(SUM_W + SKEW_FRAC - 1) : STEP_W'(SUM_W - 1);
            dvd_reg  <= dividend;
            den_reg  <= divisor;
            rem_reg  <= '0;
            q_reg    <= '0;
            ovf_reg  <= 1'b0;
        end else if (busy_reg) begin
            step_reg <= step_reg + 1'b1;
            dvd_reg  <= {dvd_reg[SUM_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            ovf_reg  <= ovf_reg || (q_next > SKEW_MAXNEG);
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;
    assign ovf      = ovf_reg;

endmodule
`default_nettype wire

// ===== rtl/csr_dp.sv =====
// Datapath: sync point table, running sums, origins, skew, multiplier and divider.
// Executes one command per cycle from csr_ctrl; depends on csr_pkg and csr_div.
`default_nettype none
module csr_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  csr_pkg::cmd_t               cmd,
    output csr_pkg::dp_stat_t           stat,
    input  logic [1:0]                  s_op,
    input  logic [csr_pkg::TIME_W-1:0]  s_stamp_global,
    input  logic [csr_pkg::TIME_W-1:0]  s_stamp_local,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [csr_pkg::LIMIT_W-1:0] cfg_wdata,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [csr_pkg::TIME_W-1:0]  m_converted_time,
    output logic [1:0]                  m_status,
    output logic [csr_pkg::OUTCNT_W-1:0] m_entry_count
);
    import csr_pkg::*;

    localparam int K_W = $clog2(CNT_W);

    // Input word and configuration.
    op_t                op_reg;
    logic [TIME_W-1:0]  g_reg;
    logic [TIME_W-1:0]  l_reg;
    logic [LIMIT_W-1:0] tl_reg;
    logic [FLIM_W-1:0]  fl_reg;

    // Regression state.
    logic [SUM_W-1:0]   sum_x_reg;
    logic [SUM_W-1:0]   sum_y_reg;
    logic [SUM_W-1:0]   sum_xy_reg;
    logic [SUM_W-1:0]   sum_xsq_reg;
    logic [SKEW_W-1:0]  skew_reg;
    logic [TIME_W-1:0]  la_reg;
    logic [TIME_W-1:0]  lo_reg;
    logic [TIME_W-1:0]  oo_reg;
    logic [TIME_W-1:0]  oa_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   oldest_reg;
    logic [FLIM_W-1:0]  fault_reg;
    logic               first_reg;

    // Work registers.
    logic [TIME_W-1:0]  t_reg;
    logic [TIME_W-1:0]  dmag_reg;
    logic               dneg_reg;
    logic [TIME_W-1:0]  conv_reg;
    status_t            status_reg;
    logic [SUM_W-1:0]   mul_p_reg;
    logic [SUM_W-1:0]   acc_reg;
    logic [TIME_W-1:0]  x_reg;
    logic [TIME_W-1:0]  y_reg;
    logic [IDX_W-1:0]   widx_reg;
    logic               full_reg;
    logic [CNT_W-1:0]   i_reg;
    logic [TIME_W-1:0]  ox_reg;
    logic [TIME_W-1:0]  oy_reg;
    logic [SUM_W-1:0]   num_reg;
    logic [SUM_W-1:0]   den_reg;

    // Point table.
    logic [TIME_W-1:0]  mem_x   [TABLE_DEPTH];
    logic [TIME_W-1:0]  mem_y   [TABLE_DEPTH];
    logic [SUM_W-1:0]   mem_xsq [TABLE_DEPTH];
    logic [SUM_W-1:0]   mem_xy  [TABLE_DEPTH];
    logic [TIME_W-1:0]  rd_x_reg;
    logic [TIME_W-1:0]  rd_y_reg;
    logic [SUM_W-1:0]   rd_xsq_reg;
    logic [SUM_W-1:0]   rd_xy_reg;

    // Result word.
    logic               m_valid_reg;
    logic [TIME_W-1:0]  m_conv_reg;
    status_t            m_status_reg;
    logic [OUTCNT_W-1:0] m_count_reg;

    // Combinational terms.
    logic [SKEW_W-1:0]  smag;
    logic [TIME_W-1:0]  conv_src;
    logic [TIME_W-1:0]  dval;
    logic [TIME_W-1:0]  mul_a;
    logic [TIME_W-1:0]  mul_b;
    logic [SUM_W-1:0]   m_sum;
    logic [SKEW_W-1:0]  m_val;
    logic [TIME_W-1:0]  term;
    logic [TIME_W-1:0]  conv_next;
    logic [TIME_W-1:0]  diff;
    logic signed [TIME_W:0] err_e;
    logic signed [TIME_W:0] err_lim;
    logic               err;
    logic [FLIM_W:0]    fc;
    logic [TIME_W-1:0]  nx;
    logic [TIME_W-1:0]  ny;
    logic [IDX_W-1:0]   rd_addr;
    logic               rd_en;
    logic [SUM_W-1:0]   xy_val;
    logic [SUM_W-1:0]   la_prod;
    logic               full;
    logic               sy_neg;
    logic [SUM_W-1:0]   sy_mag;
    logic               pow2;
    logic [K_W-1:0]     k;
    logic signed [SUM_W-1:0] sy_shift;
    logic [SUM_W-1:0]   oa_div;
    logic               num_neg;
    logic [SUM_W-1:0]   q_sat;
    logic [SUM_W-1:0]   skew_val;

    logic               div_start;
    logic               div_frac;
    logic [SUM_W-1:0]   div_dividend;
    logic [SUM_W-1:0]   div_divisor;
    logic               div_busy;
    logic [SUM_W-1:0]   div_q;
    logic               div_ovf;

    csr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .frac     (div_frac),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_q),
        .ovf      (div_ovf)
    );

    assign full = (cnt_reg == CNT_W'(TABLE_DEPTH));

    // Conversion: local to global adds the origins, global to local removes them.
    always_comb begin
        smag     = skew_reg[SKEW_W-1] ? -skew_reg : skew_reg;
        conv_src = (op_reg == OP_G2L) ? g_reg - oa_reg - oo_reg : l_reg;
        dval     = conv_src - la_reg - lo_reg;
        m_sum    = mul_p_reg + {32'b0, acc_reg[55:24]};
        m_val    = m_sum[SUM_W-1:16];
        if (m_val == '0) begin
            term = '0;
        end else if (skew_reg[SKEW_W-1] != dneg_reg) begin
            term = (m_val > 48'h0000_8000_0000) ? 32'h8000_0000 : m_val[TIME_W-1:0];
            term = -term;
        end else begin
            term = (m_val > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : m_val[TIME_W-1:0];
        end
        conv_next = (op_reg == OP_G2L) ? t_reg - term : t_reg + oo_reg + oa_reg + term;
    end

    always_comb begin
        diff    = g_reg - conv_reg;
        err_e   = $signed({diff[TIME_W-1], diff});
        err_lim = $signed({{(TIME_W + 1 - LIMIT_W){1'b0}}, tl_reg});
        err     = (err_e > err_lim) || (err_e < -err_lim);
        fc      = {1'b0, fault_reg} + 1'b1;
        nx      = l_reg - lo_reg;
        ny      = g_reg - l_reg - oo_reg;
    end

    always_comb begin
        case (cmd)
            C_MUL_SLO: begin
                mul_a = {8'b0, smag[23:0]};
                mul_b = dmag_reg;
            end
            C_MUL_SHI: begin
                mul_a = {8'b0, smag[47:24]};
                mul_b = dmag_reg;
            end
            C_MUL_XX: begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            C_MUL_YX: begin
                mul_a = y_reg;
                mul_b = x_reg;
            end
            C_MUL_LA_YLO: begin
                mul_a = la_reg;
                mul_b = sum_y_reg[31:0];
            end
            C_MUL_LA_YHI: begin
                mul_a = la_reg;
                mul_b = sum_y_reg[63:32];
            end
            C_MUL_LA_XLO: begin
                mul_a = la_reg;
                mul_b = sum_x_reg[31:0];
            end
            C_MUL_LA_XHI: begin
                mul_a = la_reg;
                mul_b = sum_x_reg[63:32];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // A signed y times an unsigned x, modulo 2^64, is the unsigned product
    // less x shifted up by 32 when y is negative.
    always_comb begin
        xy_val  = mul_p_reg - (y_reg[TIME_W-1] ? {x_reg, 32'b0} : 64'b0);
        la_prod = acc_reg + {mul_p_reg[31:0], 32'b0};
        rd_en   = (cmd == C_RD_OLD) || (cmd == C_RD_LOOP);
        rd_addr = (cmd == C_RD_LOOP) ? idx_add(oldest_reg, i_reg) : oldest_reg;
    end

    always_comb begin
        sy_neg = sum_y_reg[SUM_W-1];
        sy_mag = sy_neg ? -sum_y_reg : sum_y_reg;
        pow2   = ((cnt_reg & (cnt_reg - 1'b1)) == '0);
        k      = '0;
        for (int b = 0; b < CNT_W; b++) begin
            if (cnt_reg[b]) begin
                k = K_W'(b);
            end
        end
        sy_shift = $signed(sum_y_reg) >>> k;
        oa_div   = sy_neg ? -div_q : div_q;
    end

    always_comb begin
        num_neg = num_reg[SUM_W-1];
        if (num_neg) begin
            q_sat    = (div_ovf || div_q > SKEW_MAXNEG) ? SKEW_MAXNEG : div_q;
            skew_val = -q_sat;
        end else begin
            q_sat    = (div_ovf || div_q > SKEW_MAXPOS) ? SKEW_MAXPOS : div_q;
            skew_val = q_sat;
        end
    end

    always_comb begin
        div_start    = (cmd == C_DIV_AX) || (cmd == C_DIV_AY) || (cmd == C_DIV_SK);
        div_frac     = (cmd == C_DIV_SK);
        div_divisor  = (cmd == C_DIV_SK) ? den_reg : {{(SUM_W - CNT_W){1'b0}}, cnt_reg};
        case (cmd)
            C_DIV_AX: div_dividend = sum_x_reg;
            C_DIV_AY: div_dividend = sy_mag;
            C_DIV_SK: div_dividend = num_neg ? -num_reg : num_reg;
            default:  div_dividend = '0;
        endcase
    end

    // Control state with reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tl_reg      <= THROWOUT_RESET;
            fl_reg      <= FAULT_RESET;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            sum_xy_reg  <= '0;
            sum_xsq_reg <= '0;
            skew_reg    <= '0;
            la_reg      <= '0;
            lo_reg      <= '0;
            oo_reg      <= '0;
            oa_reg      <= '0;
            cnt_reg     <= '0;
            oldest_reg  <= '0;
            fault_reg   <= '0;
            first_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_THROWOUT: tl_reg <= cfg_wdata;
                    REG_FAULT:    fl_reg <= cfg_wdata[FLIM_W-1:0];
                    default:      ;
                endcase
            end
            if (cmd == C_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (cmd)
                C_FIRST: begin
                    if (first_reg) begin
                        first_reg <= 1'b0;
                        lo_reg    <= l_reg;
                        oo_reg    <= g_reg - l_reg;
                    end
                end
                C_CHECK: begin
                    if (!err) begin
                        fault_reg <= '0;
                    end else if (fc > {1'b0, fl_reg}) begin
                        fault_reg <= '0;
                    end else begin
                        fault_reg <= fc[FLIM_W-1:0];
                    end
                end
                C_SUB_OLD: begin
                    sum_x_reg   <= sum_x_reg - {32'b0, rd_x_reg};
                    sum_y_reg   <= sum_y_reg - {{32{rd_y_reg[TIME_W-1]}}, rd_y_reg};
                    sum_xy_reg  <= sum_xy_reg - rd_xy_reg;
                    sum_xsq_reg <= sum_xsq_reg - rd_xsq_reg;
                end
                C_CLR_SUMS: begin
                    sum_x_reg   <= '0;
                    sum_y_reg   <= '0;
                    sum_xy_reg  <= '0;
                    sum_xsq_reg <= '0;
                end
                C_WRITE, C_WRITE_NEW: begin
                    sum_x_reg   <= sum_x_reg + {32'b0, x_reg};
                    sum_y_reg   <= sum_y_reg + {{32{y_reg[TIME_W-1]}}, y_reg};
                    sum_xy_reg  <= sum_xy_reg + xy_val;
                    sum_xsq_reg <= sum_xsq_reg + acc_reg;
                    if (cmd == C_WRITE_NEW) begin
                        if (full_reg) begin
                            oldest_reg <= idx_add(oldest_reg, CNT_W'(1));
                        end else begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                C_ORIGIN: begin
                    lo_reg <= lo_reg + ox_reg;
                    oo_reg <= oo_reg + oy_reg;
                end
                C_SET_LA: la_reg <= div_q[TIME_W-1:0];
                C_SET_OA: oa_reg <= pow2 ? sy_shift[TIME_W-1:0] : oa_div[TIME_W-1:0];
                C_SKEW_ZERO: skew_reg <= '0;
                C_SKEW_SET: skew_reg <= skew_val[SKEW_W-1:0];
                default: ;
            endcase
        end
    end

    // Work and payload registers.
    always_ff @(posedge aclk) begin
        mul_p_reg <= mul_a * mul_b;
        case (cmd)
            C_LOAD: begin
                op_reg <= s_op;
                g_reg  <= s_stamp_global;
                l_reg  <= s_stamp_local;
                if (s_op == OP_ADD) begin
                    status_reg <= ST_ADDED;
                end else if (s_op == OP_L2G || s_op == OP_G2L) begin
                    status_reg <= ST_CONVERTED;
                end else begin
                    status_reg <= ST_DROPPED;
                end
            end
            C_CONV_LD: begin
                t_reg    <= conv_src;
                dneg_reg <= dval[TIME_W-1];
                dmag_reg <= dval[TIME_W-1] ? -dval : dval;
            end
            C_MUL_SHI, C_MUL_YX, C_MUL_LA_YHI, C_MUL_LA_XHI: acc_reg <= mul_p_reg;
            C_TERM: conv_reg <= conv_next;
            C_CHECK: begin
                if (err) begin
                    status_reg <= (fc > {1'b0, fl_reg}) ? ST_FAULT_RESET : ST_DROPPED;
                end
            end
            C_OLD_LATCH: begin
                ox_reg <= rd_x_reg;
                oy_reg <= rd_y_reg;
            end
            C_CLR_SUMS: i_reg <= CNT_W'(1);
            C_REN_XY: begin
                x_reg    <= rd_x_reg - ox_reg;
                y_reg    <= rd_y_reg - oy_reg;
                widx_reg <= idx_add(oldest_reg, i_reg);
                i_reg    <= i_reg + 1'b1;
            end
            C_NEW_XY: begin
                x_reg    <= nx;
                y_reg    <= ny;
                widx_reg <= full ? oldest_reg : idx_add(oldest_reg, cnt_reg);
                full_reg <= full;
            end
            C_NUM: num_reg <= sum_xy_reg - la_prod;
            C_DEN: den_reg <= sum_xsq_reg - la_prod;
            C_OUT: begin
                m_conv_reg   <= (op_reg == OP_L2G || op_reg == OP_G2L) ? conv_reg : '0;
                m_status_reg <= status_reg;
                m_count_reg  <= OUTCNT_W'(cnt_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd == C_WRITE || cmd == C_WRITE_NEW) begin
            mem_x[widx_reg]   <= x_reg;
            mem_y[widx_reg]   <= y_reg;
            mem_xsq[widx_reg] <= acc_reg;
            mem_xy[widx_reg]  <= xy_val;
        end
        if (rd_en) begin
            rd_x_reg   <= mem_x[rd_addr];
            rd_y_reg   <= mem_y[rd_addr];
            rd_xsq_reg <= mem_xsq[rd_addr];
            rd_xy_reg  <= mem_xy[rd_addr];
        end
    end

    always_comb begin
        stat.op        = op_reg;
        stat.full      = full;
        stat.above_min = (cnt_reg > CNT_W'(CHECK_MIN));
        stat.err       = err;
        stat.renorm    = (nx < rd_x_reg) || (ny[TIME_W-1] ^ rd_y_reg[TIME_W-1]);
        stat.ren_done  = (i_reg == CNT_W'(TABLE_DEPTH));
        stat.div_busy  = div_busy;
        stat.single    = (cnt_reg == CNT_W'(1));
        stat.den_zero  = (den_reg == '0);
        stat.out_free  = !m_valid_reg || m_ready;
    end

    assign m_valid          = m_valid_reg;
    assign m_converted_time = m_conv_reg;
    assign m_status         = m_status_reg;
    assign m_entry_count    = m_count_reg;

endmodule
`default_nettype wire

// ===== rtl/csr_ctrl.sv =====
// Controller: sequences the datapath commands for add and conversion words.
// Depends on csr_pkg for the command and status types.
`default_nettype none
module csr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  csr_pkg::dp_stat_t stat,
    output csr_pkg::cmd_t     cmd
);
    import csr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE, S_DISPATCH, S_FIRST, S_CV_LD, S_CV_MLO, S_CV_MHI, S_CV_TERM, S_CHECK,
        S_RD_OLD, S_OLD, S_SUB_OLD, S_CLR, S_REN_RD, S_REN_XY, S_REN_MXX, S_REN_MYX,
        S_REN_WR, S_ORIGIN, S_NEW_XY, S_MXX, S_MYX, S_WR,
        S_AVG_X, S_AVG_XW, S_SET_LA, S_AVG_Y, S_AVG_YW, S_SET_OA, S_SK_ZERO,
        S_SK_YLO, S_SK_YHI, S_SK_NUM, S_SK_XLO, S_SK_XHI, S_SK_DEN, S_SK_DIV,
        S_SK_W, S_SK_SET, S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = C_NOP;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd        = C_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (stat.op == OP_ADD) begin
                    state_next = S_FIRST;
                end else if (stat.op == OP_L2G || stat.op == OP_G2L) begin
                    state_next = S_CV_LD;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_FIRST: begin
                cmd = C_FIRST;
                if (stat.above_min) begin
                    state_next = S_CV_LD;
                end else begin
                    state_next = stat.full ? S_RD_OLD : S_NEW_XY;
                end
            end
            S_CV_LD: begin
                cmd        = C_CONV_LD;
                state_next = S_CV_MLO;
            end
            S_CV_MLO: begin
                cmd        = C_MUL_SLO;
                state_next = S_CV_MHI;
            end
            S_CV_MHI: begin
                cmd        = C_MUL_SHI;
                state_next = S_CV_TERM;
            end
            S_CV_TERM: begin
                cmd        = C_TERM;
                state_next = (stat.op == OP_ADD) ? S_CHECK : S_OUT;
            end
            S_CHECK: begin
                cmd = C_CHECK;
                if (stat.err) begin
                    state_next = S_OUT;
                end else begin
                    state_next = stat.full ? S_RD_OLD : S_NEW_XY;
                end
            end
            S_RD_OLD: begin
                cmd        = C_RD_OLD;
                state_next = S_OLD;
            end
            S_OLD: begin
                cmd        = C_OLD_LATCH;
                state_next = stat.renorm ? S_CLR : S_SUB_OLD;
            end
            S_SUB_OLD: begin
                cmd        = C_SUB_OLD;
                state_next = S_NEW_XY;
            end
            S_CLR: begin
                cmd        = C_CLR_SUMS;
                state_next = S_REN_RD;
            end
            S_REN_RD: begin
                cmd        = C_RD_LOOP;
                state_next = S_REN_XY;
            end
            S_REN_XY: begin
                cmd        = C_REN_XY;
                state_next = S_REN_MXX;
            end
            S_REN_MXX: begin
                cmd        = C_MUL_XX;
                state_next = S_REN_MYX;
            end
            S_REN_MYX: begin
                cmd        = C_MUL_YX;
                state_next = S_REN_WR;
            end
            S_REN_WR: begin
                cmd        = C_WRITE;
                state_next = stat.ren_done ? S_ORIGIN : S_REN_RD;
            end
            S_ORIGIN: begin
                cmd        = C_ORIGIN;
                state_next = S_NEW_XY;
            end
            S_NEW_XY: begin
                cmd        = C_NEW_XY;
                state_next = S_MXX;
            end
            S_MXX: begin
                cmd        = C_MUL_XX;
                state_next = S_MYX;
            end
            S_MYX: begin
                cmd        = C_MUL_YX;
                state_next = S_WR;
            end
            S_WR: begin
                cmd        = C_WRITE_NEW;
                state_next = S_AVG_X;
            end
            S_AVG_X: begin
                cmd        = C_DIV_AX;
                state_next = S_AVG_XW;
            end
            S_AVG_XW: begin
                if (!stat.div_busy) begin
                    state_next = S_SET_LA;
                end
            end
            S_SET_LA: begin
                cmd        = C_SET_LA;
                state_next = S_AVG_Y;
            end
            S_AVG_Y: begin
                cmd        = C_DIV_AY;
                state_next = S_AVG_YW;
            end
            S_AVG_YW: begin
                if (!stat.div_busy) begin
                    state_next = S_SET_OA;
                end
            end
            S_SET_OA: begin
                cmd        = C_SET_OA;
                state_next = stat.single ? S_SK_ZERO : S_SK_YLO;
            end
            S_SK_ZERO: begin
                cmd        = C_SKEW_ZERO;
                state_next = S_OUT;
            end
            S_SK_YLO: begin
                cmd        = C_MUL_LA_YLO;
                state_next = S_SK_YHI;
            end
            S_SK_YHI: begin
                cmd        = C_MUL_LA_YHI;
                state_next = S_SK_NUM;
            end
            S_SK_NUM: begin
                cmd        = C_NUM;
                state_next = S_SK_XLO;
            end
            S_SK_XLO: begin
                cmd        = C_MUL_LA_XLO;
                state_next = S_SK_XHI;
            end
            S_SK_XHI: begin
                cmd        = C_MUL_LA_XHI;
                state_next = S_SK_DEN;
            end
            S_SK_DEN: begin
                cmd        = C_DEN;
                state_next = S_SK_DIV;
            end
            S_SK_DIV: begin
                // A zero denominator leaves the skew as it was.
                if (stat.den_zero) begin
                    state_next = S_OUT;
                end else begin
                    cmd        = C_DIV_SK;
                    state_next = S_SK_W;
                end
            end
            S_SK_W: begin
                if (!stat.div_busy) begin
                    state_next = S_SK_SET;
                end
            end
            S_SK_SET: begin
                cmd        = C_SKEW_SET;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd        = C_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule
`default_nettype wire
